// ----- hdl/sos_pkg.sv -----
// shared constants and types for the slab order sizer
`timescale 1ns / 1ps

package sos_pkg;

    localparam int OBJ_W      = 24;
    localparam int ALIGN_W    = 17;
    localparam int ORDER_W    = 4;
    localparam int COUNT_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int PAGE_SHIFT_BITS = 12;
    localparam int ORDER_LIMIT     = 11;
    localparam int PTR_BYTES       = 8;
    localparam int ALIGN_MIN       = 8;
    localparam int DEFAULT_COUNT   = 4;
    // log2 of one more than the largest object count per slab
    localparam int OBJ_LIMIT_LOG   = 15;

    localparam int FIT_ORDERS = 2 ** ORDER_W;
    localparam int LOG_W      = OBJ_W + COUNT_W;
    localparam int CLOG_W     = $clog2(LOG_W + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_ORDER = 2'd0,
        REG_MAX_ORDER = 2'd1,
        REG_MIN_COUNT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [FIT_ORDERS-1:0] f16;
        logic [FIT_ORDERS-1:0] f8;
        logic [FIT_ORDERS-1:0] f4;
    } fit_t;

    typedef struct packed {
        logic              done;
        logic [CLOG_W-1:0] bits;
    } clog_t;

endpackage

// ----- hdl/sos_if.sv -----
// request, response and configuration channels of the slab order sizer
`timescale 1ns / 1ps

interface sos_req_if import sos_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OBJ_W-1:0]   object_bytes;
    logic [ALIGN_W-1:0] align_request;

    modport source (output valid, output object_bytes, output align_request, input ready);
    modport sink (input valid, input object_bytes, input align_request, output ready);
endinterface

interface sos_rsp_if import sos_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OBJ_W-1:0]   slot_bytes;
    logic [ORDER_W-1:0] page_order;
    logic               order_valid;

    modport source (output valid, output slot_bytes, output page_order, output order_valid,
                    input ready);
    modport sink (input valid, input slot_bytes, input page_order, input order_valid,
                  output ready);
endinterface

interface sos_cfg_if import sos_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/sos_fit.sv -----
// serial remainder unit: leftover of each slab order, one quotient bit per cycle
`timescale 1ns / 1ps

module sos_fit import sos_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [OBJ_W-1:0] size,
    output fit_t             fit,
    output logic             done
);

    localparam int T_FIRST = PAGE_SHIFT_BITS;
    localparam int T_LAST  = PAGE_SHIFT_BITS + FIT_ORDERS - 1;
    localparam int T_W     = $clog2(T_LAST + 1);
    localparam int CMP_W   = T_LAST + 2;

    logic [OBJ_W-1:0] r_reg, r_next;
    logic [T_W-1:0]   t_reg, t_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    fit_t             fit_reg, fit_next;

    logic [OBJ_W:0]     dbl;
    logic [OBJ_W:0]     red;
    logic [T_W-1:0]     ord_full;
    logic [ORDER_W-1:0] ord;
    logic [CMP_W-1:0]   r_wide;

    always_comb
    begin
        dbl      = {r_reg, 1'b0};
        red      = (dbl >= {1'b0, size}) ? dbl - {1'b0, size} : dbl;
        ord_full = t_reg - T_W'(T_FIRST);
        ord      = ord_full[ORDER_W-1:0];
        r_wide   = CMP_W'(r_reg);

        r_next    = r_reg;
        t_next    = t_reg;
        run_next  = run_reg;
        done_next = done_reg;
        fit_next  = fit_reg;

        if (start)
        begin
            r_next    = OBJ_W'(1);
            t_next    = '0;
            run_next  = 1'b1;
            done_next = 1'b0;
            fit_next  = '0;
        end
        else if (run_reg)
        begin
            // r holds 2^t mod size; slab of order t-12 has 2^t bytes
            if (t_reg >= T_W'(T_FIRST))
            begin
                fit_next.f16[ord] = r_wide <= (CMP_W'(1) << (t_reg - T_W'(4)));
                fit_next.f8[ord]  = r_wide <= (CMP_W'(1) << (t_reg - T_W'(3)));
                fit_next.f4[ord]  = r_wide <= (CMP_W'(1) << (t_reg - T_W'(2)));
            end
            r_next = red[OBJ_W-1:0];
            t_next = t_reg + T_W'(1);
            if (t_reg == T_W'(T_LAST))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg   <= r_next;
        t_reg   <= t_next;
        fit_reg <= fit_next;
    end

    assign fit  = fit_reg;
    assign done = done_reg;

endmodule

// ----- hdl/sos_clog.sv -----
// bit-serial ceiling log2: shifts x-1 right until empty
`timescale 1ns / 1ps

module sos_clog import sos_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [LOG_W-1:0] value,
    output clog_t            stat
);

    logic [LOG_W-1:0]  sh_reg, sh_next;
    logic [CLOG_W-1:0] cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;

    always_comb
    begin
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = done_reg;

        if (start)
        begin
            sh_next   = value - LOG_W'(1);
            cnt_next  = '0;
            run_next  = 1'b1;
            done_next = 1'b0;
        end
        else if (run_reg)
        begin
            if (sh_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                sh_next  = sh_reg >> 1;
                cnt_next = cnt_reg + CLOG_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        cnt_reg <= cnt_next;
    end

    assign stat.done = done_reg;
    assign stat.bits = cnt_reg;

endmodule

// ----- hdl/slab_order_sizer.sv -----
// slab order sizer top level: rounding, order search and channel handling
`timescale 1ns / 1ps

// req carries an object size and an alignment request; rsp returns the rounded
// slot size, the chosen slab page order and a found flag, one word per request.
// cfg writes min page order (index 0), max page order (1) and min object count (2);
// it is always ready; the user must write it only while no request is in flight, which
// the block does not enforce. req is taken only when the engine is idle, one at a time.
// a zero or oversize request goes from rounding straight to emit; otherwise the
// remainder sweep over the slab orders takes 28 steps, the two serial log shifters
// run beside it, then the order scan tries one candidate floor order at a time
// (up to 16).
// the engine takes no new request before its last result is in the output register.
// the result sits in an output register; while rsp is stalled the word holds and
// the engine may already take and work on the next request; that result then waits
// in the engine, with req not ready, until the output register frees.
// reset clears the engine, empties the output register and loads the register
// defaults: min order 0, max order 3, min object count 0 (meaning 4).
module slab_order_sizer import sos_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    sos_req_if.sink    req,
    sos_rsp_if.source  rsp,
    sos_cfg_if.sink    cfg
);

    localparam int X_W       = OBJ_W + 1;
    localparam int A_W       = ALIGN_W + 1;
    localparam int E_W       = CLOG_W + 1;
    localparam int BIG_SHIFT = OBJ_LIMIT_LOG - PAGE_SHIFT_BITS;
    localparam int G_OFFSET  = OBJ_LIMIT_LOG - PAGE_SHIFT_BITS - 1;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_ROUND  = 8'b0000_0010,
        ST_PREP   = 8'b0000_0100,
        ST_LAUNCH = 8'b0000_1000,
        ST_RUN    = 8'b0001_0000,
        ST_EVAL   = 8'b0010_0000,
        ST_SCAN   = 8'b0100_0000,
        ST_EMIT   = 8'b1000_0000
    } state_t;

    function automatic logic [ORDER_W-1:0] lowest_set(input logic [FIT_ORDERS-1:0] v);
        logic [ORDER_W-1:0] idx;
        idx = '0;
        for (int i = FIT_ORDERS - 1; i >= 0; i--)
        begin
            if (v[i])
                idx = ORDER_W'(i);
        end
        return idx;
    endfunction

    function automatic logic [E_W-1:0] order_of(input logic [E_W-1:0] cl);
        return (cl > E_W'(PAGE_SHIFT_BITS)) ? cl - E_W'(PAGE_SHIFT_BITS) : '0;
    endfunction

    function automatic logic [E_W-1:0] max_e(input logic [E_W-1:0] a, input logic [E_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [E_W-1:0] min_e(input logic [E_W-1:0] a, input logic [E_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    state_t              state_reg, state_next;
    logic [ORDER_W-1:0]  min_order_reg, max_order_reg;
    logic [COUNT_W-1:0]  min_count_reg;
    logic [X_W-1:0]      x_reg, x_next;
    logic [A_W-1:0]      a_reg, a_next;
    logic [OBJ_W-1:0]    size_reg, size_next;
    logic [LOG_W-1:0]    prod_reg, prod_next;
    logic [ORDER_W-1:0]  l_reg, l_next;
    logic [ORDER_W-1:0]  llo_reg, llo_next;
    logic [ORDER_W-1:0]  lower1_reg, lower1_next;
    logic                fb_valid_reg, fb_valid_next;
    logic [ORDER_W-1:0]  res_order_reg, res_order_next;
    logic                res_valid_reg, res_valid_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [OBJ_W-1:0]    rsp_slot_reg, rsp_slot_next;
    logic [ORDER_W-1:0]  rsp_order_reg, rsp_order_next;
    logic                rsp_ok_reg, rsp_ok_next;

    logic [ALIGN_W-1:0]    a_floor;
    logic [X_W-1:0]        x_round;
    logic [A_W-1:0]        a_round;
    logic [A_W-1:0]        a_m1;
    logic [X_W-1:0]        size_full;
    logic [COUNT_W-1:0]    ceff;
    logic                  unit_start;
    fit_t                  fit;
    logic                  fit_done;
    clog_t                 clog_s, clog_c;
    logic [E_W-1:0]        cl_s, cl_s1, cl_c, g_e;
    logic [E_W-1:0]        mpo_e, maxpo_e;
    logic [E_W-1:0]        lhi_e, llo_e, low1_e;
    logic                  big, multi, big_ok, fb_ok;
    logic [FIT_ORDERS-1:0] range, h16, h8, h4;

    sos_fit u_fit (
        .clk   (clk),
        .rst_n (rst_n),
        .start (unit_start),
        .size  (size_reg),
        .fit   (fit),
        .done  (fit_done)
    );

    sos_clog u_clog_size (
        .clk   (clk),
        .rst_n (rst_n),
        .start (unit_start),
        .value (LOG_W'(size_reg)),
        .stat  (clog_s)
    );

    sos_clog u_clog_count (
        .clk   (clk),
        .rst_n (rst_n),
        .start (unit_start),
        .value (prod_reg),
        .stat  (clog_c)
    );

    assign req.ready  = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;
    assign unit_start = (state_reg == ST_LAUNCH);

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.slot_bytes  = rsp_slot_reg;
    assign rsp.page_order  = rsp_order_reg;
    assign rsp.order_valid = rsp_ok_reg;

    always_comb
    begin
        // input rounding
        a_floor   = (req.align_request < ALIGN_W'(ALIGN_MIN)) ? ALIGN_W'(ALIGN_MIN)
                                                              : req.align_request;
        x_round   = (X_W'(req.object_bytes) + X_W'(PTR_BYTES - 1)) & ~X_W'(PTR_BYTES - 1);
        a_round   = (A_W'(a_floor) + A_W'(PTR_BYTES - 1)) & ~A_W'(PTR_BYTES - 1);
        a_m1      = a_reg - A_W'(1);
        size_full = (x_reg + X_W'(a_m1)) & ~X_W'(a_m1);
        ceff      = (min_count_reg == '0) ? COUNT_W'(DEFAULT_COUNT) : min_count_reg;

        // order bounds from the log results
        cl_s    = E_W'(clog_s.bits);
        cl_s1   = cl_s + E_W'(1);
        cl_c    = E_W'(clog_c.bits);
        g_e     = cl_s + E_W'(G_OFFSET);
        mpo_e   = E_W'(min_order_reg);
        maxpo_e = E_W'(max_order_reg);
        big     = (min_order_reg >= ORDER_W'(BIG_SHIFT))
                  && (size_reg <= (OBJ_W'(1) << (min_order_reg - ORDER_W'(BIG_SHIFT))));
        multi   = (ceff >= COUNT_W'(2)) && (cl_s1 <= E_W'(PAGE_SHIFT_BITS) + maxpo_e);
        lhi_e   = max_e(mpo_e, min_e(order_of(cl_c), maxpo_e));
        llo_e   = max_e(mpo_e, order_of(cl_s1));
        low1_e  = max_e(mpo_e, order_of(cl_s));
        big_ok  = (g_e <= maxpo_e) || (g_e < E_W'(ORDER_LIMIT));
        fb_ok   = (low1_e <= maxpo_e) || (low1_e < E_W'(ORDER_LIMIT));

        // candidate orders between the floor and max order
        range = ({FIT_ORDERS{1'b1}} << l_reg)
                & ({FIT_ORDERS{1'b1}} >> (ORDER_W'(FIT_ORDERS - 1) - max_order_reg));
        h16   = fit.f16 & range;
        h8    = fit.f8 & range;
        h4    = fit.f4 & range;

        state_next     = state_reg;
        x_next         = x_reg;
        a_next         = a_reg;
        size_next      = size_reg;
        prod_next      = prod_reg;
        l_next         = l_reg;
        llo_next       = llo_reg;
        lower1_next    = lower1_reg;
        fb_valid_next  = fb_valid_reg;
        res_order_next = res_order_reg;
        res_valid_next = res_valid_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_slot_next  = rsp_slot_reg;
        rsp_order_next = rsp_order_reg;
        rsp_ok_next    = rsp_ok_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    x_next     = x_round;
                    a_next     = a_round;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                res_order_next = '0;
                res_valid_next = 1'b0;
                if (size_full[OBJ_W])
                begin
                    size_next  = '1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    size_next  = size_full[OBJ_W-1:0];
                    state_next = (size_full == '0) ? ST_EMIT : ST_PREP;
                end
            end
            ST_PREP:
            begin
                prod_next  = LOG_W'(ceff) * LOG_W'(size_reg);
                state_next = ST_LAUNCH;
            end
            ST_LAUNCH:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (fit_done && clog_s.done && clog_c.done)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                lower1_next   = low1_e[ORDER_W-1:0];
                fb_valid_next = fb_ok;
                l_next        = lhi_e[ORDER_W-1:0];
                llo_next      = llo_e[ORDER_W-1:0];
                priority if (big)
                begin
                    // object count cap: every trial gives the same order
                    res_order_next = big_ok ? g_e[ORDER_W-1:0] : '0;
                    res_valid_next = big_ok;
                    state_next     = ST_EMIT;
                end
                else if (multi)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    res_order_next = fb_ok ? low1_e[ORDER_W-1:0] : '0;
                    res_valid_next = fb_ok;
                    state_next     = ST_EMIT;
                end
            end
            ST_SCAN:
            begin
                priority if (h4 != '0)
                begin
                    priority if (h16 != '0)
                        res_order_next = lowest_set(h16);
                    else if (h8 != '0)
                        res_order_next = lowest_set(h8);
                    else
                        res_order_next = lowest_set(h4);
                    res_valid_next = 1'b1;
                    state_next     = ST_EMIT;
                end
                else if (l_reg == llo_reg)
                begin
                    res_order_next = fb_valid_reg ? lower1_reg : '0;
                    res_valid_next = fb_valid_reg;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    l_next = l_reg - ORDER_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_slot_next  = size_reg;
                    rsp_order_next = res_order_reg;
                    rsp_ok_next    = res_valid_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            min_order_reg <= ORDER_W'(0);
            max_order_reg <= ORDER_W'(3);
            min_count_reg <= COUNT_W'(0);
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_MIN_ORDER: min_order_reg <= cfg.data[ORDER_W-1:0];
                    REG_MAX_ORDER: max_order_reg <= cfg.data[ORDER_W-1:0];
                    REG_MIN_COUNT: min_count_reg <= cfg.data[COUNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        a_reg         <= a_next;
        size_reg      <= size_next;
        prod_reg      <= prod_next;
        l_reg         <= l_next;
        llo_reg       <= llo_next;
        lower1_reg    <= lower1_next;
        fb_valid_reg  <= fb_valid_next;
        res_order_reg <= res_order_next;
        res_valid_reg <= res_valid_next;
        rsp_slot_reg  <= rsp_slot_next;
        rsp_order_reg <= rsp_order_next;
        rsp_ok_reg    <= rsp_ok_next;
    end

endmodule

// ----- hdl/sos_checker.sv -----
// port checker for the slab order sizer and its bind
`timescale 1ns / 1ps

module sos_checker import sos_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [OBJ_W-1:0]   slot_bytes,
    input logic [ORDER_W-1:0] page_order,
    input logic               order_valid
);

    // stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(slot_bytes)
                                   && $stable(page_order) && $stable(order_valid))
        else $error("response word changed while stalled");

    // one request in flight
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while engine busy");

    // failed search reports order zero
    a_fail_order: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !order_valid |-> page_order == '0)
        else $error("nonzero order on failed search");

    // found order implies a real, pointer aligned slot
    a_found_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && order_valid |-> slot_bytes != '0 && slot_bytes[2:0] == 3'b000
                                     && slot_bytes != '1)
        else $error("order found for empty or oversize slot");

endmodule

bind slab_order_sizer sos_checker u_sos_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .slot_bytes  (rsp.slot_bytes),
    .page_order  (rsp.page_order),
    .order_valid (rsp.order_valid)
);

// ----- verif/tb.sv -----
// testbench for slab_order_sizer: directed table, then random words against a sizing predictor
`timescale 1ns / 1ps

module tb;
    import sos_pkg::*;

    localparam longint unsigned OBJ_CAP  = (64'd1 << OBJ_LIMIT_LOG) - 1;
    localparam int unsigned     NO_ORDER = 32'hFFFF_FFFF;
    localparam int              HOLD_CYCLES  = 400;
    localparam int              PHASE_WORDS  = 100;
    localparam int              DRAIN_CYCLES = 60;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [OBJ_W-1:0]   slot;
        logic [ORDER_W-1:0] order;
        logic               found;
    } sizing_t;

    typedef struct packed {
        logic [OBJ_W-1:0]   obj;
        logic [ALIGN_W-1:0] align;
        logic               known;
        sizing_t            want;
    } vector_t;

    typedef struct packed {
        logic [3:0] lo_order;
        logic [3:0] hi_order;
        logic [7:0] count;
        idle_mode_t mode;
        logic       hold;
    } phase_t;

    logic clk;
    logic rst_n;

    sos_req_if req_ch ();
    sos_rsp_if rsp_ch ();
    sos_cfg_if cfg_ch ();

    slab_order_sizer uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    sizing_t sizing_q [$];
    int errors = 0;
    int tx_pct = 0;
    int rx_pct = 0;
    int hold_token = 0;

    int unsigned fit_min_order = 0;
    int unsigned fit_max_order = 3;
    int unsigned fit_min_count = 0;

    vector_t vectors [20] = '{
        '{24'h000000, 17'h00000, 1'b1, '{24'h000000, 4'd0, 1'b0}},
        '{24'h000001, 17'h00000, 1'b1, '{24'h000008, 4'd0, 1'b1}},
        '{24'h000008, 17'h00000, 1'b1, '{24'h000008, 4'd0, 1'b1}},
        '{24'hFFFFFF, 17'h00000, 1'b1, '{24'hFFFFFF, 4'd0, 1'b0}},
        '{24'h800000, 17'h00000, 1'b1, '{24'h800000, 4'd0, 1'b0}},
        '{24'hFFFFF8, 17'h00008, 1'b0, '0},
        '{24'hFFFFF9, 17'h00000, 1'b0, '0},
        '{24'h000001, 17'h1FFFF, 1'b0, '0},
        '{24'h000001, 17'h10000, 1'b0, '0},
        '{24'h000000, 17'h1FFFF, 1'b0, '0},
        '{24'd100,    17'd64,    1'b0, '0},
        '{24'd3000,   17'd0,     1'b0, '0},
        '{24'd4096,   17'd4096,  1'b0, '0},
        '{24'd5000,   17'd12,    1'b0, '0},
        '{24'd33,     17'd24,    1'b0, '0},
        '{24'd2049,   17'd0,     1'b0, '0},
        '{24'h000001, 17'h00004, 1'b0, '0},
        '{24'h7FFFFF, 17'h00000, 1'b0, '0},
        '{24'h555555, 17'h0AAAA, 1'b0, '0},
        '{24'hAAAAAA, 17'h15555, 1'b0, '0}
    };

    phase_t phases [12] = '{
        '{4'd0,  4'd3,  8'd0,   IDLE_NONE, 1'b0},
        '{4'd0,  4'd0,  8'd0,   IDLE_SEND, 1'b0},
        '{4'd10, 4'd10, 8'd255, IDLE_RECV, 1'b0},
        '{4'd6,  4'd10, 8'd1,   IDLE_NONE, 1'b1},
        '{4'd7,  4'd2,  8'd4,   IDLE_BOTH, 1'b0},
        '{4'd0,  4'd10, 8'd0,   IDLE_SEND, 1'b0},
        '{4'd2,  4'd5,  8'd16,  IDLE_RECV, 1'b0},
        '{4'd8,  4'd8,  8'd2,   IDLE_BOTH, 1'b0},
        '{4'd0,  4'd1,  8'd255, IDLE_RECV, 1'b1},
        '{4'd10, 4'd0,  8'd3,   IDLE_SEND, 1'b0},
        '{4'd1,  4'd4,  8'd8,   IDLE_NONE, 1'b0},
        '{4'd3,  4'd7,  8'd0,   IDLE_BOTH, 1'b0}
    };

    function automatic longint unsigned round_to(longint unsigned x, longint unsigned a);
        return (x + a - 1) & ~(a - 1);
    endfunction

    function automatic longint unsigned slab_span(int unsigned o);
        return 64'd1 << (PAGE_SHIFT_BITS + o);
    endfunction

    function automatic int unsigned order_to_hold(longint unsigned nbytes);
        int unsigned o;
        o = 0;
        while (o < 47 && slab_span(o) < nbytes)
            o++;
        return o;
    endfunction

    function automatic int unsigned trial_order(longint unsigned size, longint unsigned want_objs,
                                                int unsigned bound, longint unsigned fract);
        int unsigned o;
        int unsigned g;
        longint unsigned sb;
        // too many objects at the floor order: cap by object count
        if (slab_span(fit_min_order) / size > OBJ_CAP)
        begin
            g = order_to_hold(size * OBJ_CAP);
            return (g == 0) ? NO_ORDER : g - 1;
        end
        o = order_to_hold(want_objs * size);
        if (o < fit_min_order)
            o = fit_min_order;
        while (o <= bound)
        begin
            sb = slab_span(o);
            if (sb % size <= sb / fract)
                break;
            o++;
        end
        return o;
    endfunction

    function automatic sizing_t predict_sizing(logic [OBJ_W-1:0] obj, logic [ALIGN_W-1:0] align_in);
        longint unsigned align;
        longint unsigned size;
        longint unsigned want;
        longint unsigned cap;
        longint unsigned fract;
        int unsigned o;
        sizing_t r;
        r = '0;
        align = (align_in < ALIGN_MIN) ? ALIGN_MIN : align_in;
        align = round_to(align, PTR_BYTES);
        size = round_to(round_to(obj, PTR_BYTES), align);
        if (size > 64'hFF_FFFF)
        begin
            r.slot = '1;
            return r;
        end
        r.slot = size[OBJ_W-1:0];
        if (size == 0)
            return r;
        want = (fit_min_count != 0) ? fit_min_count : DEFAULT_COUNT;
        cap = slab_span(fit_max_order) / size;
        if (want > cap)
            want = cap;
        while (want > 1)
        begin
            for (fract = 16; fract >= 4; fract = fract / 2)
            begin
                o = trial_order(size, want, fit_max_order, fract);
                if (o <= fit_max_order)
                begin
                    r.order = o[ORDER_W-1:0];
                    r.found = 1'b1;
                    return r;
                end
            end
            want--;
        end
        o = trial_order(size, 1, fit_max_order, 1);
        if (o <= fit_max_order)
        begin
            r.order = o[ORDER_W-1:0];
            r.found = 1'b1;
            return r;
        end
        o = trial_order(size, 1, ORDER_LIMIT, 1);
        if (o < ORDER_LIMIT)
        begin
            r.order = o[ORDER_W-1:0];
            r.found = 1'b1;
        end
        return r;
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            REG_MIN_ORDER: fit_min_order = 32'(value[3:0]);
            REG_MAX_ORDER: fit_max_order = 32'(value[3:0]);
            REG_MIN_COUNT: fit_min_count = 32'(value);
            default: ;
        endcase
    endtask

    task automatic offer_word(logic [OBJ_W-1:0] obj, logic [ALIGN_W-1:0] align, logic known,
                              sizing_t typed);
        int gap;
        gap = ($urandom_range(99) < tx_pct) ? $urandom_range(1, 80) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.object_bytes  <= obj;
        req_ch.align_request <= align;
        do @(posedge clk); while (!req_ch.ready);
        sizing_q.push_back(known ? typed : predict_sizing(obj, align));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL slab_order_sizer");
        $finish;
    end

    // response side: random stalls, long hold on request, in-order check
    initial
    begin
        int hold_seen;
        int hold_left;
        sizing_t want;
        hold_seen = 0;
        hold_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (sizing_q.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected word: expected none got slot %h order %0d found %b",
                             $time, rsp_ch.slot_bytes, rsp_ch.page_order, rsp_ch.order_valid);
                end
                else
                begin
                    want = sizing_q.pop_front();
                    if (rsp_ch.slot_bytes !== want.slot)
                    begin
                        errors++;
                        $display("%0t slot_bytes: expected %h got %h",
                                 $time, want.slot, rsp_ch.slot_bytes);
                    end
                    if (rsp_ch.page_order !== want.order)
                    begin
                        errors++;
                        $display("%0t page_order: expected %0d got %0d",
                                 $time, want.order, rsp_ch.page_order);
                    end
                    if (rsp_ch.order_valid !== want.found)
                    begin
                        errors++;
                        $display("%0t order_valid: expected %b got %b",
                                 $time, want.found, rsp_ch.order_valid);
                    end
                end
            end
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rx_pct);
        end
    end

    initial
    begin
        logic [OBJ_W-1:0]   obj;
        logic [ALIGN_W-1:0] align;
        int unsigned        sel;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.object_bytes = '0;
        req_ch.align_request = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_MIN_ORDER;
        cfg_ch.data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vectors[i])
            offer_word(vectors[i].obj, vectors[i].align, vectors[i].known, vectors[i].want);

        foreach (phases[p])
        begin
            req_ch.valid <= 1'b0;
            while (sizing_q.size() != 0)
                @(posedge clk);
            write_reg(REG_MIN_ORDER, {4'd0, phases[p].lo_order});
            write_reg(REG_MAX_ORDER, {4'd0, phases[p].hi_order});
            write_reg(REG_MIN_COUNT, phases[p].count);
            cfg_ch.valid <= 1'b0;
            case (phases[p].mode)
                IDLE_NONE: begin tx_pct = 0;  rx_pct <= 0;  end
                IDLE_SEND: begin tx_pct = 60; rx_pct <= 0;  end
                IDLE_RECV: begin tx_pct = 0;  rx_pct <= 60; end
                default:   begin tx_pct = 35; rx_pct <= 35; end
            endcase
            if (phases[p].hold)
                hold_token <= hold_token + 1;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // sender pause until the block has drained
                if (phases[p].hold && n == PHASE_WORDS / 2)
                begin
                    req_ch.valid <= 1'b0;
                    while (sizing_q.size() != 0)
                        @(posedge clk);
                end
                sel = $urandom_range(99);
                if (sel < 45)
                    obj = OBJ_W'($urandom_range(1, 512));
                else if (sel < 70)
                    obj = OBJ_W'($urandom_range(1, 16384));
                else if (sel < 85)
                    obj = OBJ_W'($urandom_range(1, 24'h100000));
                else if (sel < 95)
                    obj = OBJ_W'($urandom_range(1, 24'h800000));
                else if (sel < 98)
                    obj = OBJ_W'($urandom());
                else
                    obj = '0;
                sel = $urandom_range(99);
                if (sel < 40)
                    align = '0;
                else if (sel < 85)
                    align = 17'd1 << $urandom_range(0, 16);
                else if (sel < 95)
                    align = ALIGN_W'($urandom_range(0, 17'h1FFFF));
                else
                    align = '1;
                offer_word(obj, align, 1'b0, '0);
            end
        end

        req_ch.valid <= 1'b0;
        while (sizing_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && sizing_q.size() == 0)
            $display("PASS slab_order_sizer");
        else
            $display("FAIL slab_order_sizer");
        $finish;
    end

endmodule
